// ===== rtl/rvd_pkg.sv =====
// Shared types and encodings for the RV64 instruction decoder.
package rvd_pkg;

	// Decoded operation kinds, dense and in fixed order.
	typedef enum logic [6:0] {
		OP_LB, OP_LH, OP_LW, OP_LD, OP_LBU, OP_LHU, OP_LWU, OP_FENCE,
		OP_ADDI, OP_SLLI, OP_SLTI, OP_SLTIU, OP_XORI, OP_ORI, OP_ANDI, OP_SRLI, OP_SRAI,
		OP_AUIPC, OP_ADDIW, OP_SLLIW, OP_SRLIW, OP_SRAIW,
		OP_SB, OP_SH, OP_SW, OP_SD,
		OP_ADD, OP_SUB, OP_MUL, OP_MULH, OP_MULHSU, OP_MULHU, OP_DIV, OP_DIVU,
		OP_REM, OP_REMU,
		OP_SLL, OP_SLT, OP_SLTU, OP_XOR, OP_SRL, OP_SRA, OP_OR, OP_AND,
		OP_LUI, OP_ADDW, OP_SUBW, OP_MULW, OP_DIVW, OP_DIVUW, OP_REMW, OP_REMUW,
		OP_SLLW, OP_SRLW, OP_SRAW,
		OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU,
		OP_JALR, OP_JAL, OP_ECALL, OP_EBREAK,
		OP_CSRRW, OP_CSRRS, OP_CSRRC, OP_CSRRWI, OP_CSRRSI, OP_CSRRCI,
		OP_CLW, OP_CLD, OP_CSW, OP_CSD, OP_CJ, OP_CLWSP, OP_CLDSP, OP_CJR, OP_CJALR,
		OP_CSWSP, OP_CSDSP
	} op_kind_t;

	// Major opcodes, instruction bits 6..2
	localparam logic [4:0] OPC_LOAD     = 5'h00;
	localparam logic [4:0] OPC_MISC_MEM = 5'h03;
	localparam logic [4:0] OPC_OP_IMM   = 5'h04;
	localparam logic [4:0] OPC_AUIPC    = 5'h05;
	localparam logic [4:0] OPC_OP_IMM32 = 5'h06;
	localparam logic [4:0] OPC_STORE    = 5'h08;
	localparam logic [4:0] OPC_OP       = 5'h0C;
	localparam logic [4:0] OPC_LUI      = 5'h0D;
	localparam logic [4:0] OPC_OP32     = 5'h0E;
	localparam logic [4:0] OPC_BRANCH   = 5'h18;
	localparam logic [4:0] OPC_JALR     = 5'h19;
	localparam logic [4:0] OPC_JAL      = 5'h1B;
	localparam logic [4:0] OPC_SYSTEM   = 5'h1C;

	// funct7 / funct6 codes
	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_MULDIV = 7'h01;
	localparam logic [6:0] F7_ALT = 7'h20;
	localparam logic [5:0] F6_BASE = 6'h00;
	localparam logic [5:0] F6_ALT = 6'h10;

	// Compressed quadrants
	localparam logic [1:0] CQ0 = 2'd0;
	localparam logic [1:0] CQ1 = 2'd1;
	localparam logic [1:0] CQ2 = 2'd2;

	// Fixed register numbers used by compressed forms
	localparam logic [4:0] REG_RA = 5'd1;
	localparam logic [4:0] REG_SP = 5'd2;

	// One decoded word
	typedef struct packed {
		op_kind_t    op_kind;
		logic [4:0]  dest_reg;
		logic [4:0]  src1_reg;
		logic [4:0]  src2_reg;
		logic [31:0] immediate;
		logic [11:0] csr_address;
		logic        is_compressed;
		logic        is_illegal;
	} rvd_dec_t;

endpackage

// ===== rtl/rvd_if.sv =====
// Valid/ready channel interfaces for instruction and decoded words.
interface rvd_instr_if;
	logic        valid;
	logic        ready;
	logic [31:0] instruction_word;

	modport source (output valid, output instruction_word, input ready);
	modport sink (input valid, input instruction_word, output ready);
endinterface

interface rvd_res_if;
	logic               valid;
	logic               ready;
	logic [6:0]         op_kind;
	logic [4:0]         dest_reg;
	logic [4:0]         src1_reg;
	logic [4:0]         src2_reg;
	logic signed [31:0] immediate;
	logic [11:0]        csr_address;
	logic               is_compressed;
	logic               is_illegal;

	modport source (output valid, output op_kind, output dest_reg, output src1_reg,
		output src2_reg, output immediate, output csr_address, output is_compressed,
		output is_illegal, input ready);
	modport sink (input valid, input op_kind, input dest_reg, input src1_reg,
		input src2_reg, input immediate, input csr_address, input is_compressed,
		input is_illegal, output ready);
endinterface

// ===== rtl/rvd_decode.sv =====
// Combinational decode of one 32-bit or 16-bit instruction word.
module rvd_decode (
	input  logic [31:0]      word,
	output rvd_pkg::rvd_dec_t dec
);
	import rvd_pkg::*;

	// legal result with no CSR field
	function automatic rvd_dec_t mk(op_kind_t k, logic [4:0] rd, logic [4:0] rs1,
		logic [4:0] rs2, logic [31:0] imm);
		rvd_dec_t r;
		r.op_kind       = k;
		r.dest_reg      = rd;
		r.src1_reg      = rs1;
		r.src2_reg      = rs2;
		r.immediate     = imm;
		r.csr_address   = '0;
		r.is_compressed = 1'b0;
		r.is_illegal    = 1'b0;
		return r;
	endfunction

	logic [4:0]  opc, rd, rs1, rs2;
	logic [2:0]  f3;
	logic [6:0]  f7;
	logic [5:0]  f6;
	logic [11:0] top;
	logic [31:0] iimm, simm, bimm, uimm, jimm;
	logic [1:0]  cq;
	logic [2:0]  cf3;
	logic [4:0]  rp1, rp2, r1, r2;
	logic [31:0] wofs, dofs, cjofs, lwsp, ldsp, swsp, sdsp;
	logic        compressed;
	rvd_dec_t    raw;

	// field extraction for both formats
	always_comb begin
		opc  = word[6:2];
		f3   = word[14:12];
		f7   = word[31:25];
		f6   = word[31:26];
		rd   = word[11:7];
		rs1  = word[19:15];
		rs2  = word[24:20];
		top  = word[31:20];
		iimm = {{20{word[31]}}, word[31:20]};
		simm = {{20{word[31]}}, word[31:25], word[11:7]};
		bimm = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
		uimm = {word[31:12], 12'b0};
		jimm = {{11{word[31]}}, word[31], word[19:12], word[20], word[30:21], 1'b0};

		cq    = word[1:0];
		cf3   = word[15:13];
		rp1   = {2'b01, word[9:7]};
		rp2   = {2'b01, word[4:2]};
		r1    = word[11:7];
		r2    = word[6:2];
		wofs  = {25'b0, word[5], word[12:10], word[6], 2'b0};
		dofs  = {24'b0, word[6:5], word[12:10], 3'b0};
		cjofs = {{20{word[12]}}, word[12], word[8], word[10:9], word[6], word[7],
			word[2], word[11], word[5:3], 1'b0};
		lwsp  = {24'b0, word[3:2], word[12], word[6:4], 2'b0};
		ldsp  = {23'b0, word[4:2], word[12], word[6:5], 3'b0};
		swsp  = {24'b0, word[8:7], word[12:9], 2'b0};
		sdsp  = {23'b0, word[9:7], word[12:10], 3'b0};

		compressed = (word[1:0] != 2'b11);
	end

	// main decode; raw.is_illegal stays set unless some arm matches
	always_comb begin
		raw = '0;
		raw.is_illegal = 1'b1;
		if (!compressed) begin
			unique case (opc)
				OPC_LOAD: begin
					unique case (f3)
						3'd0: raw = mk(OP_LB, rd, rs1, '0, iimm);
						3'd1: raw = mk(OP_LH, rd, rs1, '0, iimm);
						3'd2: raw = mk(OP_LW, rd, rs1, '0, iimm);
						3'd3: raw = mk(OP_LD, rd, rs1, '0, iimm);
						3'd4: raw = mk(OP_LBU, rd, rs1, '0, iimm);
						3'd5: raw = mk(OP_LHU, rd, rs1, '0, iimm);
						3'd6: raw = mk(OP_LWU, rd, rs1, '0, iimm);
						default: ;
					endcase
				end
				OPC_MISC_MEM: begin
					if (f3 == 3'd0) raw = mk(OP_FENCE, rd, rs1, '0, iimm);
				end
				OPC_OP_IMM: begin
					unique case (f3)
						3'd0: raw = mk(OP_ADDI, rd, rs1, '0, iimm);
						3'd1: if (f6 == F6_BASE) raw = mk(OP_SLLI, rd, rs1, '0, iimm);
						3'd2: raw = mk(OP_SLTI, rd, rs1, '0, iimm);
						3'd3: raw = mk(OP_SLTIU, rd, rs1, '0, iimm);
						3'd4: raw = mk(OP_XORI, rd, rs1, '0, iimm);
						3'd5: begin
							if (f6 == F6_BASE) raw = mk(OP_SRLI, rd, rs1, '0, iimm);
							else if (f6 == F6_ALT) raw = mk(OP_SRAI, rd, rs1, '0, iimm);
						end
						3'd6: raw = mk(OP_ORI, rd, rs1, '0, iimm);
						default: raw = mk(OP_ANDI, rd, rs1, '0, iimm);
					endcase
				end
				OPC_AUIPC: raw = mk(OP_AUIPC, rd, '0, '0, uimm);
				OPC_OP_IMM32: begin
					if (f3 == 3'd0) raw = mk(OP_ADDIW, rd, rs1, '0, iimm);
					else if (f3 == 3'd1 && f7 == F7_BASE) raw = mk(OP_SLLIW, rd, rs1, '0, iimm);
					else if (f3 == 3'd5 && f7 == F7_BASE) raw = mk(OP_SRLIW, rd, rs1, '0, iimm);
					else if (f3 == 3'd5 && f7 == F7_ALT) raw = mk(OP_SRAIW, rd, rs1, '0, iimm);
				end
				OPC_STORE: begin
					unique case (f3)
						3'd0: raw = mk(OP_SB, '0, rs1, rs2, simm);
						3'd1: raw = mk(OP_SH, '0, rs1, rs2, simm);
						3'd2: raw = mk(OP_SW, '0, rs1, rs2, simm);
						3'd3: raw = mk(OP_SD, '0, rs1, rs2, simm);
						default: ;
					endcase
				end
				OPC_OP: begin
					if (f7 == F7_MULDIV) begin
						unique case (f3)
							3'd0: raw = mk(OP_MUL, rd, rs1, rs2, '0);
							3'd1: raw = mk(OP_MULH, rd, rs1, rs2, '0);
							3'd2: raw = mk(OP_MULHSU, rd, rs1, rs2, '0);
							3'd3: raw = mk(OP_MULHU, rd, rs1, rs2, '0);
							3'd4: raw = mk(OP_DIV, rd, rs1, rs2, '0);
							3'd5: raw = mk(OP_DIVU, rd, rs1, rs2, '0);
							3'd6: raw = mk(OP_REM, rd, rs1, rs2, '0);
							default: raw = mk(OP_REMU, rd, rs1, rs2, '0);
						endcase
					end else if (f7 == F7_BASE) begin
						unique case (f3)
							3'd0: raw = mk(OP_ADD, rd, rs1, rs2, '0);
							3'd1: raw = mk(OP_SLL, rd, rs1, rs2, '0);
							3'd2: raw = mk(OP_SLT, rd, rs1, rs2, '0);
							3'd3: raw = mk(OP_SLTU, rd, rs1, rs2, '0);
							3'd4: raw = mk(OP_XOR, rd, rs1, rs2, '0);
							3'd5: raw = mk(OP_SRL, rd, rs1, rs2, '0);
							3'd6: raw = mk(OP_OR, rd, rs1, rs2, '0);
							default: raw = mk(OP_AND, rd, rs1, rs2, '0);
						endcase
					end else if (f7 == F7_ALT && f3 == 3'd0) begin
						raw = mk(OP_SUB, rd, rs1, rs2, '0);
					end else if (f7 == F7_ALT && f3 == 3'd5) begin
						raw = mk(OP_SRA, rd, rs1, rs2, '0);
					end
				end
				OPC_LUI: raw = mk(OP_LUI, rd, '0, '0, uimm);
				OPC_OP32: begin
					if (f7 == F7_MULDIV) begin
						unique case (f3)
							3'd0: raw = mk(OP_MULW, rd, rs1, rs2, '0);
							3'd4: raw = mk(OP_DIVW, rd, rs1, rs2, '0);
							3'd5: raw = mk(OP_DIVUW, rd, rs1, rs2, '0);
							3'd6: raw = mk(OP_REMW, rd, rs1, rs2, '0);
							3'd7: raw = mk(OP_REMUW, rd, rs1, rs2, '0);
							default: ;
						endcase
					end else if (f7 == F7_BASE) begin
						unique case (f3)
							3'd0: raw = mk(OP_ADDW, rd, rs1, rs2, '0);
							3'd1: raw = mk(OP_SLLW, rd, rs1, rs2, '0);
							3'd5: raw = mk(OP_SRLW, rd, rs1, rs2, '0);
							default: ;
						endcase
					end else if (f7 == F7_ALT) begin
						unique case (f3)
							3'd0: raw = mk(OP_SUBW, rd, rs1, rs2, '0);
							3'd5: raw = mk(OP_SRAW, rd, rs1, rs2, '0);
							default: ;
						endcase
					end
				end
				OPC_BRANCH: begin
					unique case (f3)
						3'd0: raw = mk(OP_BEQ, '0, rs1, rs2, bimm);
						3'd1: raw = mk(OP_BNE, '0, rs1, rs2, bimm);
						3'd4: raw = mk(OP_BLT, '0, rs1, rs2, bimm);
						3'd5: raw = mk(OP_BGE, '0, rs1, rs2, bimm);
						3'd6: raw = mk(OP_BLTU, '0, rs1, rs2, bimm);
						3'd7: raw = mk(OP_BGEU, '0, rs1, rs2, bimm);
						default: ;
					endcase
				end
				OPC_JALR: begin
					if (f3 == 3'd0) raw = mk(OP_JALR, rd, rs1, '0, iimm);
				end
				OPC_JAL: raw = mk(OP_JAL, rd, '0, '0, jimm);
				OPC_SYSTEM: begin
					// CSR forms carry rs1 (or the zimm) in the immediate as well
					unique case (f3)
						3'd0: begin
							if (rd == 5'd0 && rs1 == 5'd0 && top == 12'd0)
								raw = mk(OP_ECALL, '0, '0, '0, '0);
							else if (rd == 5'd0 && rs1 == 5'd0 && top == 12'd1)
								raw = mk(OP_EBREAK, '0, '0, '0, '0);
						end
						3'd1: raw = mk(OP_CSRRW, rd, rs1, '0, {27'b0, rs1});
						3'd2: raw = mk(OP_CSRRS, rd, rs1, '0, {27'b0, rs1});
						3'd3: raw = mk(OP_CSRRC, rd, rs1, '0, {27'b0, rs1});
						3'd5: raw = mk(OP_CSRRWI, rd, rs1, '0, {27'b0, rs1});
						3'd6: raw = mk(OP_CSRRSI, rd, rs1, '0, {27'b0, rs1});
						3'd7: raw = mk(OP_CSRRCI, rd, rs1, '0, {27'b0, rs1});
						default: ;
					endcase
					if (f3 != 3'd0 && f3 != 3'd4) raw.csr_address = top;
				end
				default: ;
			endcase
		end else begin
			unique case (cq)
				CQ0: begin
					unique case (cf3)
						3'd2: raw = mk(OP_CLW, rp2, rp1, '0, wofs);
						3'd3: raw = mk(OP_CLD, rp2, rp1, '0, dofs);
						3'd6: raw = mk(OP_CSW, '0, rp1, rp2, wofs);
						3'd7: raw = mk(OP_CSD, '0, rp1, rp2, dofs);
						default: ;
					endcase
				end
				CQ1: begin
					if (cf3 == 3'd5) raw = mk(OP_CJ, '0, '0, '0, cjofs);
				end
				CQ2: begin
					unique case (cf3)
						3'd2: if (r1 != 5'd0) raw = mk(OP_CLWSP, r1, REG_SP, '0, lwsp);
						3'd3: if (r1 != 5'd0) raw = mk(OP_CLDSP, r1, REG_SP, '0, ldsp);
						3'd4: begin
							if (r1 != 5'd0 && r2 == 5'd0) begin
								if (!word[12]) raw = mk(OP_CJR, '0, r1, '0, '0);
								else raw = mk(OP_CJALR, REG_RA, r1, '0, '0);
							end
						end
						3'd6: raw = mk(OP_CSWSP, '0, REG_SP, r2, swsp);
						3'd7: raw = mk(OP_CSDSP, '0, REG_SP, r2, sdsp);
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	// illegal words report all-zero fields
	always_comb begin
		if (raw.is_illegal) begin
			dec = '0;
			dec.is_illegal = 1'b1;
		end else begin
			dec = raw;
		end
		dec.is_compressed = compressed;
	end

endmodule

// ===== rtl/rv64_instruction_decoder.sv =====
// RV64IMC + Zicsr instruction decoder, top level with input and result registers.
// Usage:
//   instr   : sink channel, one 32-bit instruction word per handshake. A word
//             whose low two bits are not 3 is decoded as a 16-bit compressed
//             instruction in bits 15..0.
//   decoded : source channel, one decoded word per instruction word: kind,
//             register numbers, immediate, CSR address, compressed and
//             illegal flags. Illegal words report zero in every field but the
//             two flags.
// Path: the input register loads at the accepting edge, and the result register
//   loads the combinational decode of that word once the result register is free.
// Throughput: one word per cycle, sustained while the receiver takes words.
// Stall: when decoded.ready is low the result register holds; the input
//   register still takes one more word, after which instr.ready drops until
//   the result is taken. No word is lost or repeated.
// Reset: arst_n clears both stage valid bits; nothing is in flight afterward.
module rv64_instruction_decoder (
	input logic           clk,
	input logic           arst_n,
	rvd_instr_if.sink     instr,
	rvd_res_if.source     decoded
);
	import rvd_pkg::*;

	logic        v_s1, v_s2;
	logic [31:0] word_s1;
	rvd_dec_t    dec_c;
	rvd_dec_t    res_s2;
	logic        s2_free;
	logic        in_fire;

	// handshake control
	assign s2_free     = !v_s2 || decoded.ready;
	assign instr.ready = !v_s1 || s2_free;
	assign in_fire     = instr.valid && instr.ready;

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_fire) v_s1 <= 1'b1;
			else if (s2_free) v_s1 <= 1'b0;
			if (s2_free) v_s2 <= v_s1;
		end
	end

	// input word register
	always_ff @(posedge clk) begin
		if (in_fire) word_s1 <= instr.instruction_word;
	end

	rvd_decode u_decode (
		.word (word_s1),
		.dec  (dec_c)
	);

	// result register
	always_ff @(posedge clk) begin
		if (s2_free && v_s1) res_s2 <= dec_c;
	end

	assign decoded.valid         = v_s2;
	assign decoded.op_kind       = 7'(res_s2.op_kind);
	assign decoded.dest_reg      = res_s2.dest_reg;
	assign decoded.src1_reg      = res_s2.src1_reg;
	assign decoded.src2_reg      = res_s2.src2_reg;
	assign decoded.immediate     = $signed(res_s2.immediate);
	assign decoded.csr_address   = res_s2.csr_address;
	assign decoded.is_compressed = res_s2.is_compressed;
	assign decoded.is_illegal    = res_s2.is_illegal;

endmodule

// ===== sim/tb_top.sv =====
// Testbench for rv64_instruction_decoder: directed, per-kind and random words checked by a predictor.
`timescale 1ns / 1ps

module tb_top;
	import rvd_pkg::*;

	// funct3 codes of the 32-bit forms
	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SRL  = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;
	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BLT  = 3'd4;
	localparam logic [2:0] F3_BGE  = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;
	localparam logic [2:0] F3_PRIV = 3'd0;
	localparam logic [2:0] F3_CSRRW  = 3'd1;
	localparam logic [2:0] F3_SYS_RSVD = 3'd4;
	localparam logic [2:0] F3_CSRRWI = 3'd5;
	localparam logic [11:0] SYS_ECALL  = 12'h000;
	localparam logic [11:0] SYS_EBREAK = 12'h001;
	localparam logic [1:0] FULL_SIZE = 2'b11;

	// funct3 codes of the compressed forms (stack-pointer forms share them)
	localparam logic [2:0] CF3_LW = 3'd2;
	localparam logic [2:0] CF3_LD = 3'd3;
	localparam logic [2:0] CF3_JR = 3'd4;
	localparam logic [2:0] CF3_J  = 3'd5;
	localparam logic [2:0] CF3_SW = 3'd6;
	localparam logic [2:0] CF3_SD = 3'd7;

	// decode tables indexed by funct3
	localparam op_kind_t IMM_OPS [8] = '{OP_ADDI, OP_SLLI, OP_SLTI, OP_SLTIU, OP_XORI,
		OP_SRLI, OP_ORI, OP_ANDI};
	localparam op_kind_t BASE_OPS [8] = '{OP_ADD, OP_SLL, OP_SLT, OP_SLTU, OP_XOR,
		OP_SRL, OP_OR, OP_AND};
	localparam op_kind_t BRANCH_OPS [8] = '{OP_BEQ, OP_BNE, OP_BEQ, OP_BEQ, OP_BLT,
		OP_BGE, OP_BLTU, OP_BGEU};

	// encode tables indexed by kind offset within a group
	localparam logic [2:0] IMM_F3 [9] = '{F3_ADD, F3_SLL, F3_SLT, F3_SLTU, F3_XOR,
		F3_OR, F3_AND, F3_SRL, F3_SRL};
	localparam logic [2:0] IMMW_F3 [4] = '{F3_ADD, F3_SLL, F3_SRL, F3_SRL};
	localparam logic [2:0] OP_F3 [18] = '{F3_ADD, F3_ADD,
		F3_ADD, F3_SLL, F3_SLT, F3_SLTU, F3_XOR, F3_SRL, F3_OR, F3_AND,
		F3_SLL, F3_SLT, F3_SLTU, F3_XOR, F3_SRL, F3_SRL, F3_OR, F3_AND};
	localparam logic [6:0] OP_F7 [18] = '{F7_BASE, F7_ALT,
		F7_MULDIV, F7_MULDIV, F7_MULDIV, F7_MULDIV, F7_MULDIV, F7_MULDIV, F7_MULDIV,
		F7_MULDIV, F7_BASE, F7_BASE, F7_BASE, F7_BASE, F7_BASE, F7_ALT, F7_BASE,
		F7_BASE};
	localparam logic [2:0] OPW_F3 [10] = '{F3_ADD, F3_ADD, F3_ADD, F3_XOR, F3_SRL,
		F3_OR, F3_AND, F3_SLL, F3_SRL, F3_SRL};
	localparam logic [6:0] OPW_F7 [10] = '{F7_BASE, F7_ALT, F7_MULDIV, F7_MULDIV,
		F7_MULDIV, F7_MULDIV, F7_MULDIV, F7_BASE, F7_BASE, F7_ALT};
	localparam logic [2:0] BR_F3 [6] = '{F3_BEQ, F3_BNE, F3_BLT, F3_BGE, F3_BLTU, F3_BGEU};
	localparam logic [2:0] C_F3 [11] = '{CF3_LW, CF3_LD, CF3_SW, CF3_SD, CF3_J,
		CF3_LW, CF3_LD, CF3_JR, CF3_JR, CF3_SW, CF3_SD};
	localparam logic [1:0] C_QUAD [11] = '{CQ0, CQ0, CQ0, CQ0, CQ1,
		CQ2, CQ2, CQ2, CQ2, CQ2, CQ2};
	localparam logic [4:0] MAJOR_OPS [13] = '{OPC_LOAD, OPC_MISC_MEM, OPC_OP_IMM,
		OPC_AUIPC, OPC_OP_IMM32, OPC_STORE, OPC_OP, OPC_LUI, OPC_OP32, OPC_BRANCH,
		OPC_JALR, OPC_JAL, OPC_SYSTEM};

	// hand-picked corner words
	localparam int EDGE_COUNT = 28;
	localparam logic [31:0] EDGE_WORDS [EDGE_COUNT] = '{
		32'h0000_0000,	// all-zero word, illegal compressed
		32'hFFFF_FFFF,	// unused major opcode
		32'h0000_0013,	// addi x0, x0, 0
		32'hFFF0_0013,	// addi with immediate -1
		32'h0000_0073,	// ecall
		32'h0010_0073,	// ebreak
		32'h0000_00F3,	// ecall form with rd set
		32'h0020_0073,	// priv form with unknown immediate
		32'h0000_4073,	// reserved system funct3
		32'hFFF0_9073,	// csrrw at top CSR
		32'hC00F_F0F3,	// csrrci with all-ones uimm
		32'h4000_5013,	// srai
		32'h0200_1013,	// slli, shamt bit 5 set
		32'h4000_1013,	// slli with alternate funct6
		32'h0400_5013,	// srli with stray funct6 bit
		32'h4000_501B,	// sraiw
		32'h0200_501B,	// srliw with funct7 one
		32'h0FF0_000F,	// fence
		32'h0000_100F,	// fence with funct3 one
		32'h0000_1067,	// jalr with funct3 one
		32'h4000_1033,	// alternate funct7 on sll
		32'h8000_006F,	// jal, most negative offset
		32'h0000_2063,	// branch with reserved funct3
		32'hFFFF_F0B7,	// lui all ones
		32'h0000_8002,	// c.jr with rs1 zero
		32'h0000_9082,	// c.jalr ra
		32'hFFFF_4002,	// c.lwsp rd zero, upper half set
		32'h0000_B001	// c.j, most negative offset
	};

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 10;
	localparam int RANDOM_WORDS = 690;
	localparam int PRINT_CAP = 40;

	typedef struct {
		logic [31:0] word;
		rvd_dec_t    dec;
	} decode_entry_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rvd_instr_if instr_ch ();
	rvd_res_if   dec_ch ();

	rv64_instruction_decoder u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.instr   (instr_ch),
		.decoded (dec_ch)
	);

	decode_entry_t pending_decodes[$];
	int            mismatch_count = 0;
	int            quiet_cycles = 0;
	bit            pacing_on = 1'b0;

	always #5 clk = ~clk;

	// one failure line, counted; printing stops after a cap
	task automatic report_mismatch(string msg);
		if (mismatch_count < PRINT_CAP)
			$display("mismatch: %s", msg);
		mismatch_count++;
	endtask

	task automatic check_field(string name, logic [31:0] word, logic [31:0] got,
		logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("word %08h %s got %0h expected %0h",
				word, name, got, want));
	endtask

	// random gap or stall length: mostly none, some short, a few long
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (!pacing_on || roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic rvd_dec_t fill_decode(op_kind_t k, logic [4:0] rd, logic [4:0] rs1,
		logic [4:0] rs2, logic [31:0] imm);
		rvd_dec_t d;
		d = '0;
		d.op_kind = k;
		d.dest_reg = rd;
		d.src1_reg = rs1;
		d.src2_reg = rs2;
		d.immediate = imm;
		return d;
	endfunction

	// expected decode of one instruction word
	function automatic rvd_dec_t predict_decode(logic [31:0] w);
		rvd_dec_t    d;
		logic [2:0]  f3;
		logic [6:0]  f7;
		logic [4:0]  rd, rs1, rs2;
		logic [31:0] iimm, simm, bimm, uimm, jimm;
		logic [4:0]  rp1, rp2;
		logic [31:0] wofs, dofs, jofs;
		d = '0;
		d.is_illegal = 1'b1;
		if (w[1:0] == FULL_SIZE) begin
			f3 = w[14:12];
			f7 = w[31:25];
			rd = w[11:7];
			rs1 = w[19:15];
			rs2 = w[24:20];
			iimm = {{20{w[31]}}, w[31:20]};
			simm = {{20{w[31]}}, w[31:25], w[11:7]};
			bimm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
			uimm = {w[31:12], 12'h000};
			jimm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
			case (w[6:2])
			OPC_LOAD: begin
				if (!(&f3))
					d = fill_decode(op_kind_t'(OP_LB + f3), rd, rs1, '0, iimm);
			end
			OPC_MISC_MEM: begin
				if (f3 == F3_ADD)
					d = fill_decode(OP_FENCE, rd, rs1, '0, iimm);
			end
			OPC_OP_IMM: begin
				if (f3 == F3_SLL || f3 == F3_SRL) begin
					if (w[31:26] == F6_BASE)
						d = fill_decode(IMM_OPS[f3], rd, rs1, '0, iimm);
					else if (f3 == F3_SRL && w[31:26] == F6_ALT)
						d = fill_decode(OP_SRAI, rd, rs1, '0, iimm);
				end else begin
					d = fill_decode(IMM_OPS[f3], rd, rs1, '0, iimm);
				end
			end
			OPC_AUIPC: d = fill_decode(OP_AUIPC, rd, '0, '0, uimm);
			OPC_OP_IMM32: begin
				if (f3 == F3_ADD)
					d = fill_decode(OP_ADDIW, rd, rs1, '0, iimm);
				else if (f3 == F3_SLL && f7 == F7_BASE)
					d = fill_decode(OP_SLLIW, rd, rs1, '0, iimm);
				else if (f3 == F3_SRL && f7 == F7_BASE)
					d = fill_decode(OP_SRLIW, rd, rs1, '0, iimm);
				else if (f3 == F3_SRL && f7 == F7_ALT)
					d = fill_decode(OP_SRAIW, rd, rs1, '0, iimm);
			end
			OPC_STORE: begin
				if (!f3[2])
					d = fill_decode(op_kind_t'(OP_SB + f3), '0, rs1, rs2, simm);
			end
			OPC_OP: begin
				if (f7 == F7_MULDIV)
					d = fill_decode(op_kind_t'(OP_MUL + f3), rd, rs1, rs2, '0);
				else if (f7 == F7_BASE)
					d = fill_decode(BASE_OPS[f3], rd, rs1, rs2, '0);
				else if (f7 == F7_ALT && f3 == F3_ADD)
					d = fill_decode(OP_SUB, rd, rs1, rs2, '0);
				else if (f7 == F7_ALT && f3 == F3_SRL)
					d = fill_decode(OP_SRA, rd, rs1, rs2, '0);
			end
			OPC_LUI: d = fill_decode(OP_LUI, rd, '0, '0, uimm);
			OPC_OP32: begin
				if (f7 == F7_MULDIV) begin
					if (f3 == F3_ADD)
						d = fill_decode(OP_MULW, rd, rs1, rs2, '0);
					else if (f3[2])
						d = fill_decode(op_kind_t'(OP_DIVW + f3[1:0]), rd, rs1, rs2, '0);
				end else if (f7 == F7_BASE) begin
					if (f3 == F3_ADD)
						d = fill_decode(OP_ADDW, rd, rs1, rs2, '0);
					else if (f3 == F3_SLL)
						d = fill_decode(OP_SLLW, rd, rs1, rs2, '0);
					else if (f3 == F3_SRL)
						d = fill_decode(OP_SRLW, rd, rs1, rs2, '0);
				end else if (f7 == F7_ALT) begin
					if (f3 == F3_ADD)
						d = fill_decode(OP_SUBW, rd, rs1, rs2, '0);
					else if (f3 == F3_SRL)
						d = fill_decode(OP_SRAW, rd, rs1, rs2, '0);
				end
			end
			OPC_BRANCH: begin
				if (f3 == F3_BEQ || f3 == F3_BNE || f3[2])
					d = fill_decode(BRANCH_OPS[f3], '0, rs1, rs2, bimm);
			end
			OPC_JALR: begin
				if (f3 == F3_ADD)
					d = fill_decode(OP_JALR, rd, rs1, '0, iimm);
			end
			OPC_JAL: d = fill_decode(OP_JAL, rd, '0, '0, jimm);
			OPC_SYSTEM: begin
				if (f3 == F3_PRIV) begin
					if (rd == '0 && rs1 == '0 && w[31:20] == SYS_ECALL)
						d = fill_decode(OP_ECALL, '0, '0, '0, '0);
					else if (rd == '0 && rs1 == '0 && w[31:20] == SYS_EBREAK)
						d = fill_decode(OP_EBREAK, '0, '0, '0, '0);
				end else if (f3 != F3_SYS_RSVD) begin
					// CSR kinds: immediate is the zero-extended rs1 field
					if (f3[2])
						d = fill_decode(op_kind_t'(int'(OP_CSRRWI) + int'(f3) - int'(F3_CSRRWI)),
							rd, rs1, '0, {27'b0, rs1});
					else
						d = fill_decode(op_kind_t'(int'(OP_CSRRW) + int'(f3) - int'(F3_CSRRW)),
							rd, rs1, '0, {27'b0, rs1});
					d.csr_address = w[31:20];
				end
			end
			default: ;
			endcase
		end else begin
			// compressed: only bits 15..0 matter
			f3 = w[15:13];
			rd = w[11:7];
			rs2 = w[6:2];
			rp1 = {2'b01, w[9:7]};
			rp2 = {2'b01, w[4:2]};
			wofs = {25'b0, w[5], w[12:10], w[6], 2'b00};
			dofs = {24'b0, w[6:5], w[12:10], 3'b000};
			jofs = {{20{w[12]}}, w[12], w[8], w[10:9], w[6], w[7], w[2], w[11], w[5:3], 1'b0};
			case (w[1:0])
			CQ0: begin
				case (f3)
				CF3_LW: d = fill_decode(OP_CLW, rp2, rp1, '0, wofs);
				CF3_LD: d = fill_decode(OP_CLD, rp2, rp1, '0, dofs);
				CF3_SW: d = fill_decode(OP_CSW, '0, rp1, rp2, wofs);
				CF3_SD: d = fill_decode(OP_CSD, '0, rp1, rp2, dofs);
				default: ;
				endcase
			end
			CQ1: begin
				if (f3 == CF3_J)
					d = fill_decode(OP_CJ, '0, '0, '0, jofs);
			end
			default: begin
				case (f3)
				CF3_LW: begin
					if (rd != '0)
						d = fill_decode(OP_CLWSP, rd, REG_SP, '0,
							{24'b0, w[3:2], w[12], w[6:4], 2'b00});
				end
				CF3_LD: begin
					if (rd != '0)
						d = fill_decode(OP_CLDSP, rd, REG_SP, '0,
							{23'b0, w[4:2], w[12], w[6:5], 3'b000});
				end
				CF3_JR: begin
					if (rd != '0 && rs2 == '0) begin
						if (w[12])
							d = fill_decode(OP_CJALR, REG_RA, rd, '0, '0);
						else
							d = fill_decode(OP_CJR, '0, rd, '0, '0);
					end
				end
				CF3_SW: d = fill_decode(OP_CSWSP, '0, REG_SP, rs2,
					{24'b0, w[8:7], w[12:9], 2'b00});
				CF3_SD: d = fill_decode(OP_CSDSP, '0, REG_SP, rs2,
					{23'b0, w[9:7], w[12:10], 3'b000});
				default: ;
				endcase
			end
			endcase
		end
		if (d.is_illegal) begin
			d = '0;
			d.is_illegal = 1'b1;
		end
		d.is_compressed = (w[1:0] != FULL_SIZE);
		return d;
	endfunction

	// a well-formed encoding of kind k with random register and immediate bits
	function automatic logic [31:0] encode_kind(op_kind_t k);
		logic [31:0] w;
		int          n;
		w = $urandom;
		n = int'(k);
		if (k >= OP_CLW) begin
			w[15:13] = C_F3[n - int'(OP_CLW)];
			w[1:0] = C_QUAD[n - int'(OP_CLW)];
			if (k == OP_CJR || k == OP_CJALR) begin
				w[12] = (k == OP_CJALR);
				w[6:2] = '0;
			end
			if ((k == OP_CLWSP || k == OP_CLDSP || k == OP_CJR || k == OP_CJALR)
				&& w[11:7] == '0)
				w[7] = 1'b1;
		end else begin
			w[1:0] = FULL_SIZE;
			if (k <= OP_LWU) begin
				w[6:2] = OPC_LOAD;
				w[14:12] = 3'(n - int'(OP_LB));
			end else if (k == OP_FENCE) begin
				w[6:2] = OPC_MISC_MEM;
				w[14:12] = F3_ADD;
			end else if (k <= OP_SRAI) begin
				w[6:2] = OPC_OP_IMM;
				w[14:12] = IMM_F3[n - int'(OP_ADDI)];
				if (k == OP_SLLI || k == OP_SRLI)
					w[31:26] = F6_BASE;
				else if (k == OP_SRAI)
					w[31:26] = F6_ALT;
			end else if (k == OP_AUIPC) begin
				w[6:2] = OPC_AUIPC;
			end else if (k <= OP_SRAIW) begin
				w[6:2] = OPC_OP_IMM32;
				w[14:12] = IMMW_F3[n - int'(OP_ADDIW)];
				if (k != OP_ADDIW)
					w[31:25] = (k == OP_SRAIW) ? F7_ALT : F7_BASE;
			end else if (k <= OP_SD) begin
				w[6:2] = OPC_STORE;
				w[14:12] = 3'(n - int'(OP_SB));
			end else if (k <= OP_AND) begin
				w[6:2] = OPC_OP;
				w[14:12] = OP_F3[n - int'(OP_ADD)];
				w[31:25] = OP_F7[n - int'(OP_ADD)];
			end else if (k == OP_LUI) begin
				w[6:2] = OPC_LUI;
			end else if (k <= OP_SRAW) begin
				w[6:2] = OPC_OP32;
				w[14:12] = OPW_F3[n - int'(OP_ADDW)];
				w[31:25] = OPW_F7[n - int'(OP_ADDW)];
			end else if (k <= OP_BGEU) begin
				w[6:2] = OPC_BRANCH;
				w[14:12] = BR_F3[n - int'(OP_BEQ)];
			end else if (k == OP_JALR) begin
				w[6:2] = OPC_JALR;
				w[14:12] = F3_ADD;
			end else if (k == OP_JAL) begin
				w[6:2] = OPC_JAL;
			end else if (k <= OP_EBREAK) begin
				w[31:7] = {(k == OP_EBREAK) ? SYS_EBREAK : SYS_ECALL, 13'b0};
				w[6:2] = OPC_SYSTEM;
			end else begin
				w[6:2] = OPC_SYSTEM;
				if (k <= OP_CSRRC)
					w[14:12] = 3'(int'(F3_CSRRW) + n - int'(OP_CSRRW));
				else
					w[14:12] = 3'(int'(F3_CSRRWI) + n - int'(OP_CSRRWI));
			end
		end
		return w;
	endfunction

	// offer one word, hold it until taken, then log its expected decode
	task automatic send_word(logic [31:0] w);
		int            gap;
		decode_entry_t entry;
		gap = pick_gap();
		if (gap > 0) begin
			instr_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		instr_ch.valid <= 1'b1;
		instr_ch.instruction_word <= w;
		do
			@(posedge clk);
		while (!instr_ch.ready);
		entry.word = w;
		entry.dec = predict_decode(w);
		pending_decodes.push_back(entry);
	endtask

	task automatic test_edge_words();
		pacing_on = 1'b0;
		for (int i = 0; i < EDGE_COUNT; i++)
			send_word(EDGE_WORDS[i]);
	endtask

	task automatic test_every_kind();
		pacing_on = 1'b1;
		for (int k = int'(OP_LB); k <= int'(OP_CSDSP); k++)
			send_word(encode_kind(op_kind_t'(k)));
	endtask

	// mostly well-formed words of random kind, the rest noise and near misses
	task automatic test_random_mix();
		logic [31:0] w;
		int          roll;
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i % 100 == 0)
				pacing_on = ((i / 100) % 3 != 2);
			roll = $urandom_range(0, 99);
			w = $urandom;
			if (roll < 70) begin
				w = encode_kind(op_kind_t'($urandom_range(int'(OP_LB), int'(OP_CSDSP))));
			end else if (roll < 85) begin
				w[1:0] = FULL_SIZE;
				w[6:2] = MAJOR_OPS[$urandom_range(0, 12)];
			end else if (roll < 95) begin
				w[1:0] = 2'($urandom_range(0, 2));
			end
			send_word(w);
		end
	endtask

	// receiver pacing: runs of ready with random stalls between
	initial begin : sink_pacing
		int run;
		int stall;
		dec_ch.ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			run = pacing_on ? $urandom_range(1, 12) : 16;
			dec_ch.ready <= 1'b1;
			repeat (run) @(posedge clk);
			stall = pick_gap();
			if (stall > 0) begin
				dec_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// compare each taken decode word with the oldest expectation
	always @(posedge clk) begin : result_check
		decode_entry_t exp_entry;
		rvd_dec_t      got;
		if (arst_n && dec_ch.valid && dec_ch.ready) begin
			got.op_kind = op_kind_t'(dec_ch.op_kind);
			got.dest_reg = dec_ch.dest_reg;
			got.src1_reg = dec_ch.src1_reg;
			got.src2_reg = dec_ch.src2_reg;
			got.immediate = dec_ch.immediate;
			got.csr_address = dec_ch.csr_address;
			got.is_compressed = dec_ch.is_compressed;
			got.is_illegal = dec_ch.is_illegal;
			if (pending_decodes.size() == 0) begin
				report_mismatch($sformatf("unexpected decode word, op_kind %0d",
					dec_ch.op_kind));
			end else begin
				exp_entry = pending_decodes.pop_front();
				check_field("op_kind", exp_entry.word, 32'(got.op_kind),
					32'(exp_entry.dec.op_kind));
				check_field("dest_reg", exp_entry.word, 32'(got.dest_reg),
					32'(exp_entry.dec.dest_reg));
				check_field("src1_reg", exp_entry.word, 32'(got.src1_reg),
					32'(exp_entry.dec.src1_reg));
				check_field("src2_reg", exp_entry.word, 32'(got.src2_reg),
					32'(exp_entry.dec.src2_reg));
				check_field("immediate", exp_entry.word, got.immediate,
					exp_entry.dec.immediate);
				check_field("csr_address", exp_entry.word, 32'(got.csr_address),
					32'(exp_entry.dec.csr_address));
				check_field("is_compressed", exp_entry.word, 32'(got.is_compressed),
					32'(exp_entry.dec.is_compressed));
				check_field("is_illegal", exp_entry.word, 32'(got.is_illegal),
					32'(exp_entry.dec.is_illegal));
			end
		end
	end

	// watchdog: cycles without any word moving on either side
	always @(posedge clk) begin
		if ((instr_ch.valid && instr_ch.ready) || (dec_ch.valid && dec_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		instr_ch.valid = 1'b0;
		instr_ch.instruction_word = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_edge_words();
		test_every_kind();
		test_random_mix();

		// drain, then give stray words time to show up
		instr_ch.valid <= 1'b0;
		while (pending_decodes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
